### hdl/lcpw_pkg.sv
// Shared definitions for the lcp-interval tree walker: field widths, codes,
// and the command, status and result structures.
// No dependencies; every other file of the block imports this package.
package lcpw_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int VALUE_BITS_DEF  = 32;

  // Widths of the stream fields as seen on the ports.
  localparam int FIELD_W      = 32;
  localparam int KIND_W       = 2;
  localparam int IN_TDATA_W   = 2 * FIELD_W;
  localparam int OUT_FIELDS_W = 4 + 6 * FIELD_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEAF   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BRANCH = 2'd2;

  // Input item codes.
  localparam logic OP_ENTRY = 1'b0;
  localparam logic OP_END   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input transaction
    logic pop;        // emit a close for the top interval and pop it
    logic reload;     // refill the top-of-stack registers from the stack memory
    logic emit_edge;  // emit the entry's edge (equal depth, push or overflow)
    logic finish;     // end of table: close a leaf-ended top, then reset
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_end;
    logic pop_needed;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               first_edge;
    logic               opened;
    logic               leaf_closed;
    logic [FIELD_W-1:0] node_depth;
    logic [FIELD_W-1:0] parent_depth;
    logic [FIELD_W-1:0] leftmost_index;
    logic [FIELD_W-1:0] rightmost_index;
    logic [FIELD_W-1:0] suffix_out;
    logic [FIELD_W-1:0] closing_lcp;
    logic               overflow;
    logic               last;
  } result_t;

endpackage

### hdl/lcpw_ctrl.sv
// Controller state machine of the lcp-interval tree walker.
// Depends on lcpw_pkg; drives commands to lcpw_dpath and reads its status.
module lcpw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  lcpw_pkg::status_t status,
  output lcpw_pkg::cmd_t    cmd
);
  import lcpw_pkg::*;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_EVAL     = 2'd1;
  localparam logic [1:0] ST_POP_WAIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // Every action here produces at most one result, so it waits for
        // the output register to be free.
        if (status.out_free) begin
          if (status.is_end) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else if (status.pop_needed) begin
            cmd.pop    = 1'b1;
            state_next = ST_POP_WAIT;
          end else begin
            cmd.emit_edge = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      ST_POP_WAIT: begin
        cmd.reload = 1'b1;
        state_next = ST_EVAL;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/lcpw_dpath.sv
// Datapath of the lcp-interval tree walker: item registers, cached stack top,
// stack memory, counters and the result register.
// Depends on lcpw_pkg; commanded by lcpw_ctrl.
module lcpw_dpath #(
  parameter int STACK_DEPTH = lcpw_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_BITS  = lcpw_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lcpw_pkg::cmd_t                  cmd,
  output lcpw_pkg::status_t               status,
  input  logic [lcpw_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output lcpw_pkg::result_t               result
);
  import lcpw_pkg::*;

  localparam int IDXW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam int EW   = 3 * VALUE_BITS + 1;

  // Captured item.
  logic                  item_end;
  logic [VALUE_BITS-1:0] item_lcp;
  logic [VALUE_BITS-1:0] item_suf;

  // Top of stack held in registers; entries below it live in the memory.
  logic [VALUE_BITS-1:0] top_depth;
  logic [VALUE_BITS-1:0] top_parent;
  logic [VALUE_BITS-1:0] top_left;
  logic                  top_leaf;
  logic [CNTW-1:0]       count;
  logic                  first_root_pending;
  logic [VALUE_BITS-1:0] entry_index;
  logic [VALUE_BITS-1:0] last_lcp;
  logic [VALUE_BITS-1:0] popped_left;

  logic [EW-1:0]         mem [STACK_DEPTH];
  logic [EW-1:0]         rd_q;
  logic [IDXW-1:0]       rd_idx;
  logic [IDXW-1:0]       wr_idx;

  logic                  depth_eq;
  logic                  full;
  logic                  do_push;
  logic                  first_root;
  logic [VALUE_BITS-1:0] push_left;
  logic [KIND_W-1:0]     edge_kind;
  result_t               result_next;

  assign depth_eq   = (item_lcp == top_depth);
  assign full       = (count >= CNTW'(STACK_DEPTH));
  assign do_push    = cmd.emit_edge && !depth_eq && !full;
  assign first_root = first_root_pending && (top_depth == '0);
  // A branch-case open reuses the leftmost index of the interval that was
  // popped last from this slot.
  assign push_left  = top_leaf ? entry_index : popped_left;
  assign edge_kind  = top_leaf ? KIND_LEAF : KIND_BRANCH;
  assign rd_idx     = IDXW'(count - CNTW'(2));
  assign wr_idx     = IDXW'(count - CNTW'(1));

  assign status.is_end     = item_end;
  assign status.pop_needed = (count > CNTW'(1)) && (item_lcp < top_depth);
  assign status.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_end <= (s_tuser == OP_END);
      item_lcp <= VALUE_BITS'(s_tdata[FIELD_W-1:0]);
      item_suf <= VALUE_BITS'(s_tdata[2*FIELD_W-1:FIELD_W]);
    end
  end

  // Stack memory: the old top is written on a push and read back on a pop.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_idx] <= {top_depth, top_parent, top_left, 1'b0};
    end
    if (cmd.pop) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_comb begin
    result_next                 = '0;
    result_next.suffix_out      = FIELD_W'(item_suf);
    result_next.rightmost_index = '0;
    if (cmd.pop || cmd.finish) begin
      result_next.kind            = KIND_CLOSE;
      result_next.leaf_closed     = top_leaf;
      result_next.node_depth      = FIELD_W'(top_depth);
      result_next.parent_depth    = FIELD_W'(top_parent);
      result_next.leftmost_index  = FIELD_W'(top_left);
      result_next.rightmost_index = FIELD_W'(entry_index);
      result_next.closing_lcp     = cmd.finish ? FIELD_W'(last_lcp) : FIELD_W'(item_lcp);
      result_next.last            = cmd.finish;
    end else if (depth_eq) begin
      result_next.kind           = edge_kind;
      result_next.first_edge     = first_root;
      result_next.node_depth     = FIELD_W'(top_depth);
      result_next.leftmost_index = FIELD_W'(top_left);
      result_next.last           = 1'b1;
    end else begin
      result_next.kind           = edge_kind;
      result_next.first_edge     = 1'b1;
      result_next.opened         = 1'b1;
      result_next.node_depth     = FIELD_W'(item_lcp);
      result_next.leftmost_index = full ? FIELD_W'(entry_index) : FIELD_W'(push_left);
      result_next.overflow       = full;
      result_next.last           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop || cmd.emit_edge || (cmd.finish && top_leaf)) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count              <= CNTW'(1);
      top_depth          <= '0;
      top_parent         <= '0;
      top_left           <= '0;
      top_leaf           <= 1'b1;
      first_root_pending <= 1'b1;
      entry_index        <= '0;
      last_lcp           <= '0;
      popped_left        <= '0;
      m_tvalid           <= 1'b0;
    end else begin
      // A new result takes the output register; otherwise a taken one frees it.
      if (cmd.pop || cmd.emit_edge || (cmd.finish && top_leaf)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.finish) begin
        count              <= CNTW'(1);
        top_depth          <= '0;
        top_parent         <= '0;
        top_left           <= '0;
        top_leaf           <= 1'b1;
        first_root_pending <= 1'b1;
        entry_index        <= '0;
        last_lcp           <= '0;
      end
      if (cmd.pop) begin
        count       <= count - CNTW'(1);
        popped_left <= top_left;
      end
      if (cmd.reload) begin
        {top_depth, top_parent, top_left, top_leaf} <= rd_q;
      end
      if (cmd.emit_edge) begin
        entry_index <= entry_index + VALUE_BITS'(1);
        last_lcp    <= item_lcp;
        if (depth_eq) begin
          top_leaf <= 1'b1;
          if (first_root) begin
            first_root_pending <= 1'b0;
          end
        end else if (!full) begin
          count      <= count + CNTW'(1);
          top_depth  <= item_lcp;
          top_parent <= top_depth;
          top_left   <= push_left;
          top_leaf   <= 1'b1;
        end
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CNTW'(STACK_DEPTH)))
    else $error("stack count out of range");

  a_pop_above_root: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (count > CNTW'(1)))
    else $error("pop issued with only the root on the stack");

  a_finish_resets: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (count == CNTW'(1)) && (top_depth == '0) && top_leaf)
    else $error("end of table did not return the stack to the root");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(cmd.pop || cmd.emit_edge || cmd.finish))
    else $error("result register written while a result is still pending");

endmodule

### hdl/lcp_interval_tree_walker.sv
// Top level of the lcp-interval tree walker: stream ports and field packing.
// Depends on lcpw_pkg, lcpw_ctrl and lcpw_dpath.
//
// This block walks the lcp-interval tree of an enhanced suffix array bottom-up.
// Each input transaction is a table entry (lcp value and suffix) or an end
// marker; an entry yields one or more results: a close for every open
// interval deeper than the entry's lcp, then one leaf or branch edge, either on
// the interval of equal depth or on a newly opened one. The end marker closes
// the top interval only when its last child edge was a leaf edge, and then
// returns the walker to its reset state. Items are handled one at a time. An
// entry is accepted, then evaluated; each interval that it closes adds a pop
// and a reload, because every pop refills the cached stack top from the
// stack memory with a registered read; an end marker is accepted, then
// evaluated. Evaluation waits while the output register is still held by a
// stalled downstream. A result waiting in the output register
// does not stop the next transaction from being accepted. A push onto a full
// stack of STACK_DEPTH intervals is dropped and flagged by overflow. No
// clearing pass is needed after reset; the block is ready on the first cycle.
module lcp_interval_tree_walker #(
  parameter int STACK_DEPTH = lcpw_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_BITS  = lcpw_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata, from bit 0: lcp_value[31:0], suffix_start[63:32]
  input  logic [lcpw_pkg::IN_TDATA_W-1:0]  s_tdata,
  // s_tuser: op (0 table entry, 1 end of table)
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata, from bit 0: first_edge, opened, leaf_closed, node_depth,
  // parent_depth, leftmost_index, rightmost_index, suffix_out, closing_lcp,
  // overflow, then zero padding to a whole byte
  output logic [lcpw_pkg::OUT_TDATA_W-1:0] m_tdata,
  // m_tuser: kind (0 close, 1 leaf edge, 2 branch edge)
  output logic [lcpw_pkg::KIND_W-1:0]      m_tuser,
  // m_tlast: last result of the input transaction
  output logic                             m_tlast
);
  import lcpw_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t result;

  lcpw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lcpw_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .result   (result)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}},
                    result.overflow,
                    result.closing_lcp,
                    result.suffix_out,
                    result.rightmost_index,
                    result.leftmost_index,
                    result.parent_depth,
                    result.node_depth,
                    result.leaf_closed,
                    result.opened,
                    result.first_edge};
  assign m_tuser = result.kind;
  assign m_tlast = result.last;

endmodule
